// ===== hw/rtl/clsr_pkg.sv =====
// Shared constants and payload types for the combined LCG shuffle generator.
`default_nettype none

package clsr_pkg;

	// Shuffle table geometry
	localparam int unsigned TABLE_DEPTH = 32;
	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// Field widths
	localparam int unsigned VAL_W = 31;
	localparam int unsigned FRAC_W = 24;
	localparam int unsigned MUL_W = 16;
	localparam int unsigned PROD_W = VAL_W + MUL_W;
	localparam int unsigned FOLD_W = 8;

	// Moduli and multipliers of the two generators
	localparam longint unsigned MOD1_L = 64'd2147483563;
	localparam longint unsigned MOD2_L = 64'd2147483399;
	localparam longint unsigned SPAN_L = MOD1_L - 64'd1;
	localparam longint unsigned BUCKET_L = 64'd1 + SPAN_L / TABLE_DEPTH;

	localparam logic [VAL_W-1:0] MOD1 = VAL_W'(MOD1_L);
	localparam logic [VAL_W-1:0] MOD2 = VAL_W'(MOD2_L);
	localparam logic [VAL_W-1:0] SPAN = VAL_W'(SPAN_L);
	localparam logic [VAL_W-1:0] BUCKET = VAL_W'(BUCKET_L);
	localparam logic [MUL_W-1:0] MUL1 = 16'd40014;
	localparam logic [MUL_W-1:0] MUL2 = 16'd40692;

	// 2^31 mod m for each modulus: folds the high part of a product back in
	localparam logic [FOLD_W-1:0] FOLD1 = FOLD_W'((64'd1 << VAL_W) - MOD1_L);
	localparam logic [FOLD_W-1:0] FOLD2 = FOLD_W'((64'd1 << VAL_W) - MOD2_L);

	// Reciprocal of the bucket size for the table index
	localparam int unsigned RECIP_SH = 37;
	localparam longint unsigned RECIP_L = (64'd1 << RECIP_SH) / BUCKET_L;
	localparam int unsigned RECIP_W = $clog2(RECIP_L + 64'd1);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
	localparam int unsigned Q_W = IDX_W + 2;
	localparam int unsigned QP_W = RECIP_SH + Q_W;
	localparam int unsigned BND_W = VAL_W + Q_W;

	// Warm-up sequence after a reseed
	localparam int unsigned WARM_STEPS = TABLE_DEPTH + 8;
	localparam int unsigned CNT_W = $clog2(WARM_STEPS);

	// Reset and output constants
	localparam logic [VAL_W-1:0] G1_RESET = VAL_W'(1);
	localparam logic [VAL_W-1:0] G2_RESET = VAL_W'(123456789);
	localparam logic [FRAC_W-1:0] FRAC_CAP = FRAC_W'((64'd1 << FRAC_W) - 64'd2);

	typedef struct packed {
		logic             reseed;
		logic [VAL_W-1:0] seed;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0]  raw_value;
		logic [FRAC_W-1:0] fraction;
		logic [VAL_W-1:0]  next_seed;
	} rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/clsr_gen_step.sv =====
// Two-lane modular multiply step for both generators: registered product, then fold.
`default_nettype none

module clsr_gen_step
	import clsr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic [VAL_W-1:0] g1,
	input  wire logic [VAL_W-1:0] g2,
	output logic      [VAL_W-1:0] nxt_g1,
	output logic      [VAL_W-1:0] nxt_g2
);

	logic [PROD_W-1:0] prod1_s1;
	logic [PROD_W-1:0] prod2_s1;

	// Reduce a product modulo m = 2^31 - k: fold the high part, then subtract once
	function automatic logic [VAL_W-1:0] fold_mod(
		input logic [PROD_W-1:0] p,
		input logic [FOLD_W-1:0] k,
		input logic [VAL_W-1:0]  m
	);
		logic [VAL_W:0] sum;
		sum = (VAL_W+1)'(p[VAL_W-1:0]) + (VAL_W+1)'(p[PROD_W-1:VAL_W]) * (VAL_W+1)'(k);
		if (sum >= {1'b0, m}) begin
			sum = sum - {1'b0, m};
		end
		return sum[VAL_W-1:0];
	endfunction

	// Capture both products every cycle; the sequencer decides when they count
	always_ff @(posedge clk) begin
		prod1_s1 <= PROD_W'(g1) * PROD_W'(MUL1);
		prod2_s1 <= PROD_W'(g2) * PROD_W'(MUL2);
	end

	assign nxt_g1 = fold_mod(prod1_s1, FOLD1, MOD1);
	assign nxt_g2 = fold_mod(prod2_s1, FOLD2, MOD2);

endmodule

`default_nettype wire

// ===== hw/rtl/combined_lcg_shuffle_rng.sv =====
// Combined two-generator LCG with shuffle table: request sequencer, table memory, output register.
//
// Usage:
//   Request channel (req_valid / req_stall / req): one transfer per deviate. With
//   req.reseed set, the seed (zero taken as one) loads both generators, generator 1
//   is stepped through the warm-up run and the shuffle table is refilled before the
//   draw. Response channel (rsp_valid / rsp_stall / rsp): one transfer per request,
//   carrying the shuffled value, its 24-bit fraction and the updated seed.
//   Steps: a plain draw passes through a registered multiply, a fold, a mix and an
//   emit step before the response is registered, and no new request is taken until
//   the draw is through. A reseed first runs the TABLE_DEPTH + 8 warm-up steps, one
//   generator step being a registered multiply followed by a fold step. The table is
//   read once and written once per draw, never both in the same cycle.
//   The response sits in an output register, so a request is accepted while an
//   earlier response still waits; a stalled receiver holds the block only when
//   the next response is ready to be written.
//   Reset sets generator 1 to 1, generator 2 to 123456789, the shuffle output to 0
//   and marks every table entry empty, which reads as zero.
`default_nettype none

module combined_lcg_shuffle_rng
	import clsr_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEED_MUL,
		ST_SEED_FOLD,
		ST_DRAW_MUL,
		ST_DRAW_FOLD,
		ST_DRAW_MIX,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [VAL_W-1:0]  g1_q;
	logic [VAL_W-1:0]  g2_q;
	logic [VAL_W-1:0]  shuf_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [VAL_W-1:0]  nxt_g1;
	logic [VAL_W-1:0]  nxt_g2;
	logic [VAL_W-1:0]  seed_ld;

	logic [QP_W-1:0]   qprod_s1;
	logic [Q_W-1:0]    q_est;
	logic [Q_W-1:0]    q_fix;
	logic [BND_W-1:0]  bnd;
	logic [IDX_W-1:0]  idx_d;
	logic [IDX_W-1:0]  idx_s2;

	logic [VAL_W-1:0]  tbl_mem [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] tbl_valid_q;
	logic              tbl_we;
	logic              tbl_re;
	logic [IDX_W-1:0]  tbl_waddr;
	logic [IDX_W-1:0]  tbl_raddr;
	logic [VAL_W-1:0]  tbl_wdata;
	logic [VAL_W-1:0]  tbl_rdata_q;
	logic              rd_valid_q;

	logic [VAL_W-1:0]  entry;
	logic [VAL_W:0]    diff;
	logic [VAL_W-1:0]  mixed;

	logic [FRAC_W-1:0] q0;
	logic [VAL_W:0]    frac_rem;
	logic [FRAC_W:0]   frac_q;
	logic [FRAC_W-1:0] frac;

	// Generator multiply-and-fold lanes
	clsr_gen_step u_gen_step (
		.clk    (clk),
		.g1     (g1_q),
		.g2     (g2_q),
		.nxt_g1 (nxt_g1),
		.nxt_g2 (nxt_g2)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Treat a zero seed as one
	assign seed_ld = (req.seed == '0) ? VAL_W'(1) : req.seed;

	// Table index: estimate by reciprocal, then correct by one bucket
	always_ff @(posedge clk) begin
		qprod_s1 <= QP_W'(shuf_q) * QP_W'(RECIP);
	end

	always_comb begin
		q_est = qprod_s1[RECIP_SH +: Q_W];
		bnd   = BND_W'(Q_W'(q_est + Q_W'(1))) * BND_W'(BUCKET);
		q_fix = q_est + Q_W'(BND_W'(shuf_q) >= bnd);
		idx_d = (q_fix >= Q_W'(TABLE_DEPTH)) ? '0 : q_fix[IDX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DRAW_FOLD) begin
			idx_s2 <= idx_d;
		end
	end

	// Table port control: warm-up fill or draw write-back, one draw read
	always_comb begin
		tbl_we    = ((state_q == ST_SEED_FOLD) && (cnt_q < CNT_W'(TABLE_DEPTH))) ||
		            (state_q == ST_DRAW_MIX);
		tbl_waddr = (state_q == ST_DRAW_MIX) ? idx_s2 : cnt_q[IDX_W-1:0];
		tbl_wdata = (state_q == ST_DRAW_MIX) ? g1_q : nxt_g1;
		tbl_re    = (state_q == ST_DRAW_FOLD);
		tbl_raddr = idx_d;
	end

	// Shuffle table memory, registered read
	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_waddr] <= tbl_wdata;
		end
		if (tbl_re) begin
			tbl_rdata_q <= tbl_mem[tbl_raddr];
			rd_valid_q  <= tbl_valid_q[tbl_raddr];
		end
	end

	// Mark entries written since reset; empty entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_valid_q <= '0;
		end else if (tbl_we) begin
			tbl_valid_q[tbl_waddr] <= 1'b1;
		end
	end

	// New shuffle output: entry minus generator 2, wrapped into range
	always_comb begin
		entry = rd_valid_q ? tbl_rdata_q : '0;
		diff  = {1'b0, entry} - {1'b0, g2_q};
		if (diff[VAL_W] || (diff == '0)) begin
			diff = diff + (VAL_W+1)'(SPAN);
		end
		mixed = diff[VAL_W-1:0];
	end

	// Fraction: high bits as first quotient, one correction, then cap
	always_comb begin
		q0       = shuf_q[VAL_W-1 -: FRAC_W];
		frac_rem = (VAL_W+1)'({shuf_q[VAL_W-FRAC_W-1:0], {FRAC_W{1'b0}}}) +
		           (VAL_W+1)'(q0) * (VAL_W+1)'(FOLD1);
		frac_q   = (FRAC_W+1)'(q0) + (FRAC_W+1)'(frac_rem >= (VAL_W+1)'(MOD1));
		frac     = (frac_q > (FRAC_W+1)'(FRAC_CAP)) ? FRAC_CAP : frac_q[FRAC_W-1:0];
	end

	// Sequencer: warm-up steps, draw, response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			g1_q        <= G1_RESET;
			g2_q        <= G2_RESET;
			shuf_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// drop the response once transferred, unless a new one takes its place
			if (rsp_valid_q && !rsp_stall && (state_q != ST_EMIT)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						if (req.reseed) begin
							g1_q    <= seed_ld;
							g2_q    <= seed_ld;
							cnt_q   <= CNT_W'(WARM_STEPS - 1);
							state_q <= ST_SEED_MUL;
						end else begin
							state_q <= ST_DRAW_MUL;
						end
					end
				end
				ST_SEED_MUL: begin
					state_q <= ST_SEED_FOLD;
				end
				ST_SEED_FOLD: begin
					g1_q <= nxt_g1;
					if (cnt_q == '0) begin
						shuf_q  <= nxt_g1;
						state_q <= ST_DRAW_MUL;
					end else begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= ST_SEED_MUL;
					end
				end
				ST_DRAW_MUL: begin
					state_q <= ST_DRAW_FOLD;
				end
				ST_DRAW_FOLD: begin
					g1_q    <= nxt_g1;
					g2_q    <= nxt_g2;
					state_q <= ST_DRAW_MIX;
				end
				ST_DRAW_MIX: begin
					shuf_q  <= mixed;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// hold until the response register is free
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.raw_value <= shuf_q;
						rsp_q.fraction  <= frac;
						rsp_q.next_seed <= g1_q;
						rsp_valid_q     <= 1'b1;
						state_q         <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(tbl_we && tbl_re))
		else $error("table read and write in the same cycle");

	a_rsp_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_EMIT))
		else $error("response raised outside the emit step");

	a_shuf_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> ((shuf_q != '0) && (shuf_q <= SPAN)))
		else $error("shuffle output out of range at emit");

	a_frac_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.fraction <= FRAC_CAP))
		else $error("fraction above cap");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_combined_lcg_shuffle_rng.sv =====
// Self-checking testbench for the combined LCG shuffle generator: predictor, scoreboard, stimulus.
`timescale 1ns / 100ps

module tb_combined_lcg_shuffle_rng
	import clsr_pkg::*;
;

	typedef longint unsigned u64_t;

	// Generator arithmetic in signed 64-bit terms
	localparam int     DEPTH    = TABLE_DEPTH;
	localparam longint M1       = MOD1_L;
	localparam longint M2       = MOD2_L;
	localparam longint A1       = MUL1;
	localparam longint A2       = MUL2;
	localparam longint Q1       = M1 / A1;
	localparam longint R1       = M1 % A1;
	localparam longint Q2       = M2 / A2;
	localparam longint R2       = M2 % A2;
	localparam longint SPAN_S   = SPAN_L;
	localparam longint BUCKET_S = BUCKET_L;

	localparam int PHASE_ITEMS    = 584;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 20;

	// Tracks generator state and the deviates still owed by the block
	class deviate_scoreboard;
		longint g1;
		longint g2;
		longint shuf;
		longint tbl [DEPTH];
		rsp_t   expected_deviates [$];
		int     errors;
		int     draws;
		int     reseeds;
		int     checked;

		function new();
			g1 = G1_RESET;
			g2 = G2_RESET;
			shuf = 0;
			foreach (tbl[i]) tbl[i] = 0;
			errors = 0;
			draws = 0;
			reseeds = 0;
			checked = 0;
		endfunction

		// Multiply modulo m by Schrage's decomposition
		function longint lcg_step(longint x, longint a, longint q, longint r, longint m);
			longint k;
			longint v;
			k = x / q;
			v = a * (x - k * q) - k * r;
			if (v < 0) v += m;
			return v;
		endfunction

		function int outstanding();
			return expected_deviates.size();
		endfunction

		// Work out the deviate owed for one accepted request
		function void note_request(req_t item);
			longint idx;
			longint s;
			u64_t   frac;
			rsp_t   want;
			if (item.reseed) begin
				s = item.seed;
				if (s < 1) s = 1;
				g1 = s;
				g2 = s;
				// warm up generator 1, keeping the last DEPTH values in the table
				for (int n = DEPTH + 7; n >= 0; n--) begin
					g1 = lcg_step(g1, A1, Q1, R1, M1);
					if (n < DEPTH) tbl[n] = g1;
				end
				shuf = tbl[0];
				reseeds++;
			end
			g1 = lcg_step(g1, A1, Q1, R1, M1);
			g2 = lcg_step(g2, A2, Q2, R2, M2);
			// pick an entry, combine it with generator 2 and refill it
			idx = shuf / BUCKET_S;
			if (idx < 0 || idx >= DEPTH) idx = 0;
			shuf = tbl[idx] - g2;
			tbl[idx] = g1;
			if (shuf < 1) shuf += SPAN_S;
			frac = (u64_t'(shuf) << FRAC_W) / u64_t'(M1);
			if (frac > u64_t'(FRAC_CAP)) frac = FRAC_CAP;
			want.raw_value = shuf[VAL_W-1:0];
			want.fraction  = frac[FRAC_W-1:0];
			want.next_seed = g1[VAL_W-1:0];
			expected_deviates.push_back(want);
			draws++;
		endfunction

		// Compare one delivered deviate with the oldest one owed
		function void check_deviate(rsp_t got);
			rsp_t want;
			if (expected_deviates.size() == 0) begin
				$error("unexpected result: raw_value %0d fraction %0d next_seed %0d",
					got.raw_value, got.fraction, got.next_seed);
				errors++;
				return;
			end
			want = expected_deviates.pop_front();
			checked++;
			if (got.raw_value !== want.raw_value) begin
				$error("raw_value mismatch: expected %0d, got %0d", want.raw_value, got.raw_value);
				errors++;
			end
			if (got.fraction !== want.fraction) begin
				$error("fraction mismatch: expected %0d, got %0d", want.fraction, got.fraction);
				errors++;
			end
			if (got.next_seed !== want.next_seed) begin
				$error("next_seed mismatch: expected %0d, got %0d", want.next_seed, got.next_seed);
				errors++;
			end
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	int   send_idle   = 0;
	int   stall_pct   = 0;
	logic hold_armed  = 1'b0;
	int   hold_left   = 0;
	int   idle_cycles = 0;

	deviate_scoreboard sb;

	combined_lcg_shuffle_rng dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Check delivered deviates; drive the output stall, with the long hold when armed
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) sb.check_deviate(rsp);
		if (hold_armed) begin
			hold_armed <= 1'b0;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// End the run if no transfer happens for too long
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", idle_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic req_t make_req(logic reseed, logic [VAL_W-1:0] seed);
		req_t r;
		r.reseed = reseed;
		r.seed = seed;
		return r;
	endfunction

	// Mostly plain draws, the odd reseed, seeds biased towards the awkward values
	function automatic req_t random_request();
		req_t r;
		r.reseed = ($urandom_range(99) < 5);
		case ($urandom_range(15))
			0:       r.seed = '0;
			1:       r.seed = MOD1;
			2:       r.seed = MOD2;
			3:       r.seed = VAL_W'($urandom_range(200, 1));
			4:       r.seed = MOD1 + VAL_W'($urandom_range(84));
			default: r.seed = VAL_W'($urandom);
		endcase
		return r;
	endfunction

	// Offer one request, after a random gap, and hold it until the transfer
	task automatic send_request(req_t item);
		while ($urandom_range(99) < send_idle) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_stall);
		sb.note_request(item);
	endtask

	// Stop offering and wait for every owed deviate
	task automatic drain();
		req_valid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	initial begin
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// draws straight from the reset state
		send_request(make_req(1'b0, '0));
		send_request(make_req(1'b0, '1));
		send_request(make_req(1'b0, 31'h2AAA_AAAA));
		// zero seed, smallest and largest seeds
		send_request(make_req(1'b1, '0));
		send_request(make_req(1'b0, '0));
		send_request(make_req(1'b1, 31'd1));
		send_request(make_req(1'b1, '1));
		send_request(make_req(1'b0, 31'h5555_5555));
		// seeds on the moduli lock a generator at zero
		send_request(make_req(1'b1, MOD1));
		send_request(make_req(1'b0, '0));
		send_request(make_req(1'b0, '1));
		send_request(make_req(1'b1, MOD2));
		send_request(make_req(1'b0, '0));
		send_request(make_req(1'b0, '1));
		// seeds around both moduli, then assorted patterns
		send_request(make_req(1'b1, MOD1 - 31'd1));
		send_request(make_req(1'b1, MOD1 + 31'd1));
		send_request(make_req(1'b1, MOD2 + 31'd1));
		send_request(make_req(1'b1, G2_RESET));
		send_request(make_req(1'b1, 31'h2AAA_AAAA));
		send_request(make_req(1'b1, 31'h5555_5555));
		send_request(make_req(1'b0, '1));
		send_request(make_req(1'b0, '0));
		drain();

		// slow receiver
		send_idle = 17;
		stall_pct = 85;
		repeat (PHASE_ITEMS) send_request(random_request());
		drain();

		// slow sender
		send_idle = 85;
		stall_pct = 17;
		repeat (PHASE_ITEMS) send_request(random_request());
		drain();

		// full rate, opening with a long output hold so the block backs up
		send_idle = 0;
		stall_pct = 0;
		hold_armed <= 1'b1;
		repeat (PHASE_ITEMS) send_request(random_request());
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Checked %0d of %0d deviates, %0d of them after a reseed,",
			sb.checked, sb.draws, sb.reseeds);
		$display("under slow-receiver, slow-sender, full-rate and long-hold pacing.");
		if (sb.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/clsr_pkg.sv
hw/rtl/clsr_gen_step.sv
hw/rtl/combined_lcg_shuffle_rng.sv
dv/tb_combined_lcg_shuffle_rng.sv
